### sv/salru_pkg.sv
// Shared types, constants and helpers of the set-associative LRU cache simulator.
package salru_pkg;

	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS     = 8;
	localparam int DEF_ADDR_WIDTH   = 32;

	localparam int CNT_W   = 32;
	localparam int STAMP_W = 32;
	localparam int QDEPTH  = 2;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_MODIFY = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	localparam logic [1:0] REG_SET_BITS    = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS        = 2'd2;

	localparam logic [2:0] RST_SET_BITS    = 3'd0;
	localparam logic [4:0] RST_OFFSET_BITS = 5'd0;
	localparam logic [3:0] RST_WAYS        = 4'd1;

	typedef struct packed {
		logic [2:0] set_index_bits;
		logic [4:0] offset_bits;
		logic [3:0] ways_in_use;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_SCAN,
		ST_WRITE
	} back_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

### sv/set_assoc_cache_lru_sim_core.sv
// Set-associative LRU cache simulator core: config registers, decoder, queue, lookup engine.
// Each access moves through read, compare, victim scan (only when it evicts; the scan
// walks one way per cycle) and write; the result is registered on the write, which waits
// while out_stall holds the result register. The engine takes one access at a time and
// pops no new word until the write is done; modify issues two accesses.
// Reset: a pass over all 2^MAX_SET_BITS sets clears the valid bits; in_stall stays high meanwhile.
module set_assoc_cache_lru_sim_core #(
	parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS,
	parameter int ADDR_WIDTH   = salru_pkg::DEF_ADDR_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [salru_pkg::PADDR_W-1:0] paddr,
	input  logic [salru_pkg::PDATA_W-1:0] pwdata,
	output logic [salru_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [31:0]                   address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic                          miss,
	output logic                          evict,
	output logic [salru_pkg::CNT_W-1:0]   hit_total,
	output logic [salru_pkg::CNT_W-1:0]   miss_total,
	output logic [salru_pkg::CNT_W-1:0]   evict_total,
	output logic                          last
);
	import salru_pkg::*;

	localparam int SetW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int EntryW = 1 + SetW + ADDR_WIDTH;

	cfg_t              cfg_q;
	logic              busy;
	logic              push, push_ready;
	logic [EntryW-1:0] push_data;
	logic              pop, q_valid;
	logic [EntryW-1:0] q_data;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_index_bits <= RST_SET_BITS;
			cfg_q.offset_bits    <= RST_OFFSET_BITS;
			cfg_q.ways_in_use    <= RST_WAYS;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_SET_BITS:    cfg_q.set_index_bits <= pwdata[2:0];
				REG_OFFSET_BITS: cfg_q.offset_bits    <= pwdata[4:0];
				REG_WAYS:        cfg_q.ways_in_use    <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SET_BITS:    prdata = PDATA_W'(cfg_q.set_index_bits);
			REG_OFFSET_BITS: prdata = PDATA_W'(cfg_q.offset_bits);
			REG_WAYS:        prdata = PDATA_W'(cfg_q.ways_in_use);
			default:         prdata = '0;
		endcase
	end

	salru_front #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.ADDR_WIDTH   (ADDR_WIDTH),
		.SET_W        (SetW),
		.ENTRY_W      (EntryW)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.address    (address),
		.cfg        (cfg_q),
		.busy       (busy),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	salru_fifo #(
		.DATA_W (EntryW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (q_valid),
		.pop_data   (q_data)
	);

	salru_back #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH),
		.SET_W        (SetW),
		.ENTRY_W      (EntryW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.busy        (busy),
		.pop         (pop),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.miss        (miss),
		.evict       (evict),
		.hit_total   (hit_total),
		.miss_total  (miss_total),
		.evict_total (evict_total),
		.last        (last)
	);

`ifndef ASSERT_OFF
	ast_hit_xor_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit != miss))
		else $error("hit and miss flags disagree");

	ast_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && evict) |-> miss)
		else $error("eviction reported on a hit");

	ast_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (hit_total != '0))
		else $error("hit reported with zero hit total");

	ast_no_push_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !push)
		else $error("word queued during valid-bit clear");
`endif

endmodule

### sv/salru_fifo.sv
// Small word queue between the request decoder and the lookup engine.
module salru_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              push_ready,
	input  logic              pop,
	output logic              pop_valid,
	output logic [DATA_W-1:0] pop_data
);
	import salru_pkg::*;

	localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CntW = $clog2(QDEPTH + 1);

	logic [DATA_W-1:0] data_q [QDEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CntW'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = data_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/salru_front.sv
// Request decoder: accepts words, drops unknown kinds, splits address into set and tag.
module salru_front #(
	parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
	parameter int ADDR_WIDTH   = salru_pkg::DEF_ADDR_WIDTH,
	parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
	parameter int ENTRY_W      = 1 + SET_W + ADDR_WIDTH
) (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [31:0]        address,
	input  salru_pkg::cfg_t    cfg,
	input  logic               busy,
	output logic               push,
	output logic [ENTRY_W-1:0] push_data,
	input  logic               push_ready
);
	import salru_pkg::*;

	localparam int SbW = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
	localparam int ShW = $clog2(32 + MAX_SET_BITS);

	logic [ADDR_WIDTH-1:0] aw_addr;
	logic [SbW-1:0]        sbits;
	logic [ShW-1:0]        shift;
	logic [ADDR_WIDTH-1:0] tag;
	logic [SET_W-1:0]      set_idx;
	logic                  twice;

	assign in_stall = busy || !push_ready;
	assign aw_addr  = ADDR_WIDTH'(address);
	assign sbits    = (cfg.set_index_bits > MAX_SET_BITS) ? SbW'(MAX_SET_BITS)
	                                                      : SbW'(cfg.set_index_bits);
	assign shift    = ShW'(cfg.offset_bits) + ShW'(sbits);
	assign tag      = (shift >= ADDR_WIDTH) ? '0 : (aw_addr >> shift);
	assign set_idx  = SET_W'(aw_addr >> cfg.offset_bits) & ~({SET_W{1'b1}} << sbits);
	assign twice    = (req_type == REQ_MODIFY);

	assign push      = in_valid && !in_stall && (req_type != REQ_NONE);
	assign push_data = {twice, set_idx, tag};

endmodule

### sv/salru_back.sv
// Lookup engine: set memory, tag compare, LRU victim scan, totals and result register.
module salru_back #(
	parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS,
	parameter int ADDR_WIDTH   = salru_pkg::DEF_ADDR_WIDTH,
	parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
	parameter int ENTRY_W      = 1 + SET_W + ADDR_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  salru_pkg::cfg_t            cfg,
	output logic                       busy,
	output logic                       pop,
	input  logic                       q_valid,
	input  logic [ENTRY_W-1:0]         q_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic                       miss,
	output logic                       evict,
	output logic [salru_pkg::CNT_W-1:0] hit_total,
	output logic [salru_pkg::CNT_W-1:0] miss_total,
	output logic [salru_pkg::CNT_W-1:0] evict_total,
	output logic                       last
);
	import salru_pkg::*;

	localparam int Sets = 1 << MAX_SET_BITS;
	localparam int TagW = ADDR_WIDTH;
	localparam int WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CntW = $clog2(MAX_WAYS + 1);

	typedef struct packed {
		logic [MAX_WAYS-1:0]               valid;
		logic [MAX_WAYS-1:0][TagW-1:0]     tag;
		logic [MAX_WAYS-1:0][STAMP_W-1:0]  stamp;
	} row_t;

	row_t             mem [Sets];
	back_state_t      state_q, state_nx;
	logic [SET_W-1:0] clr_idx_q;
	logic [SET_W-1:0] cur_set_q;
	logic [TagW-1:0]  cur_tag_q;
	logic             twice_q;
	row_t             row_q;
	logic [STAMP_W-1:0] acc_q;
	logic [WayW-1:0]  way_q;
	logic             hit_q;
	logic             evict_q;
	logic [WayW-1:0]  scan_idx_q;
	logic [STAMP_W-1:0] best_q;
	logic [CNT_W-1:0] hits_q, misses_q, evicts_q;
	logic [CNT_W-1:0] hits_nx, misses_nx, evicts_nx;
	logic             out_valid_q;
	logic             out_hit_q, out_evict_q, out_last_q;
	logic [CNT_W-1:0] out_hits_q, out_misses_q, out_evicts_q;

	logic             head_twice;
	logic [SET_W-1:0] head_set;
	logic [TagW-1:0]  head_tag;
	logic [CntW-1:0]  ways;
	logic [MAX_WAYS-1:0] in_use, hit_vec, inv_vec;
	logic             any_hit, any_inv;
	logic [WayW-1:0]  hit_way, inv_way;
	logic [STAMP_W-1:0] age;
	logic             scan_last;
	logic             out_free;
	logic             rd_en, wr_en, acc_inc, done_access;
	logic [SET_W-1:0] rd_set, wr_set;
	row_t             wr_row;

	assign {head_twice, head_set, head_tag} = q_data;

	assign ways = (cfg.ways_in_use == '0) ? CntW'(1) :
	              (cfg.ways_in_use > MAX_WAYS) ? CntW'(MAX_WAYS) : CntW'(cfg.ways_in_use);

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w]  = (CntW'(w) < ways);
			hit_vec[w] = in_use[w] && row_q.valid[w] && (row_q.tag[w] == cur_tag_q);
			inv_vec[w] = in_use[w] && !row_q.valid[w];
		end
	end

	always_comb begin
		hit_way = '0;
		inv_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WayW'(w);
			end
			if (inv_vec[w]) begin
				inv_way = WayW'(w);
			end
		end
	end

	assign any_hit   = |hit_vec;
	assign any_inv   = |inv_vec;
	assign age       = acc_q - row_q.stamp[scan_idx_q];
	assign scan_last = (CntW'(scan_idx_q) == ways - 1'b1);
	assign out_free  = !out_valid_q || !out_stall;
	assign busy      = (state_q == ST_CLEAR);

	assign hits_nx   = hit_q ? sat_inc(hits_q) : hits_q;
	assign misses_nx = hit_q ? misses_q : sat_inc(misses_q);
	assign evicts_nx = evict_q ? sat_inc(evicts_q) : evicts_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == SET_W'(Sets - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					state_nx = ST_CMP;
				end
			end
			ST_READ: begin
				state_nx = ST_CMP;
			end
			ST_CMP: begin
				state_nx = (any_hit || any_inv) ? ST_WRITE : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_nx = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_nx = twice_q ? ST_READ : ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		pop         = 1'b0;
		rd_en       = 1'b0;
		wr_en       = 1'b0;
		acc_inc     = 1'b0;
		done_access = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					rd_en   = 1'b1;
					acc_inc = 1'b1;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				acc_inc = 1'b1;
			end
			ST_WRITE: begin
				if (out_free) begin
					wr_en       = 1'b1;
					done_access = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_set = (state_q == ST_IDLE) ? head_set : cur_set_q;
	assign wr_set = (state_q == ST_CLEAR) ? clr_idx_q : cur_set_q;

	always_comb begin
		wr_row = row_q;
		if (state_q == ST_CLEAR) begin
			wr_row = '0;
		end else begin
			wr_row.valid[way_q] = 1'b1;
			wr_row.tag[way_q]   = cur_tag_q;
			wr_row.stamp[way_q] = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			row_q <= mem[rd_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			acc_q       <= '0;
			twice_q     <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (acc_inc) begin
				acc_q <= acc_q + 1'b1;
			end
			if (pop) begin
				twice_q <= head_twice;
			end else if (done_access) begin
				twice_q <= 1'b0;
			end
			if (done_access) begin
				hits_q      <= hits_nx;
				misses_q    <= misses_nx;
				evicts_q    <= evicts_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_set_q <= head_set;
			cur_tag_q <= head_tag;
		end
		case (state_q)
			ST_CMP: begin
				way_q      <= any_hit ? hit_way : inv_way;
				hit_q      <= any_hit;
				evict_q    <= !any_hit && !any_inv;
				scan_idx_q <= '0;
			end
			ST_SCAN: begin
				if (scan_idx_q == '0 || age > best_q) begin
					best_q <= age;
					way_q  <= scan_idx_q;
				end
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (done_access) begin
			out_hit_q    <= hit_q;
			out_evict_q  <= evict_q;
			out_last_q   <= !twice_q;
			out_hits_q   <= hits_nx;
			out_misses_q <= misses_nx;
			out_evicts_q <= evicts_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign miss        = !out_hit_q;
	assign evict       = out_evict_q;
	assign hit_total   = out_hits_q;
	assign miss_total  = out_misses_q;
	assign evict_total = out_evicts_q;
	assign last        = out_last_q;

endmodule
